>>> sv/crc16_pkg.sv
// Shared constants and byte-fold functions for the dual-order CRC-16 unit.
package crc16_pkg;

	localparam int unsigned CrcW    = 16;
	localparam int unsigned ByteW   = 8;
	localparam int unsigned CfgIdxW = 2;

	localparam logic [CrcW-1:0] PolyMsbFirst = 16'h1021;
	localparam logic [CrcW-1:0] PolyLsbFirst = 16'h8408;
	localparam logic [CrcW-1:0] SeedReset    = 16'hFFFF;

	// Configuration register indexes
	localparam logic [CfgIdxW-1:0] CfgSeedValue = 2'd0;
	localparam logic [CfgIdxW-1:0] CfgBitOrder  = 2'd1;

	// Bit order codes
	localparam logic OrderMsbFirst = 1'b0;
	localparam logic OrderLsbFirst = 1'b1;

	// Fold one byte into the high byte, shift left, polynomial 0x1021
	function automatic logic [CrcW-1:0] fold_msb_first(
		input logic [CrcW-1:0]  rem,
		input logic [ByteW-1:0] data
	);
		logic [CrcW-1:0] r;
		r = rem ^ {data, {(CrcW-ByteW){1'b0}}};
		for (int k = 0; k < ByteW; k++) begin
			if (r[CrcW-1]) begin
				r = {r[CrcW-2:0], 1'b0} ^ PolyMsbFirst;
			end else begin
				r = {r[CrcW-2:0], 1'b0};
			end
		end
		return r;
	endfunction

	// Fold one byte into the low byte, shift right, reflected polynomial 0x8408
	function automatic logic [CrcW-1:0] fold_lsb_first(
		input logic [CrcW-1:0]  rem,
		input logic [ByteW-1:0] data
	);
		logic [CrcW-1:0] r;
		r = rem ^ {{(CrcW-ByteW){1'b0}}, data};
		for (int k = 0; k < ByteW; k++) begin
			if (r[0]) begin
				r = {1'b0, r[CrcW-1:1]} ^ PolyLsbFirst;
			end else begin
				r = {1'b0, r[CrcW-1:1]};
			end
		end
		return r;
	endfunction

endpackage

>>> sv/crc16_ccitt_dual_order_unit.sv
// Streaming CRC-16 CCITT unit with selectable MSB-first or LSB-first bit order.
// Each item passes the input register, the byte fold, then the result register.
// Throughput: one item per cycle when not stalled; the byte fold is one XOR network.
// The running remainder feeds back through that network, so each item sees the last one.
// Reset (arst_n low, asynchronous): pipeline empty, running remainder and seed 0xFFFF,
// bit order MSB-first.
module crc16_ccitt_dual_order_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	// input item channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [crc16_pkg::ByteW-1:0]         data_byte,
	input  logic                                first_byte,
	input  logic                                last_byte,
	// result item channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [crc16_pkg::CrcW-1:0]          remainder,
	output logic                                message_done,
	// configuration write channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [crc16_pkg::CfgIdxW-1:0]       cfg_index,
	input  logic [crc16_pkg::CrcW-1:0]          cfg_data
);

	logic                          s1_valid_s1;
	logic [crc16_pkg::ByteW-1:0]   data_byte_s1;
	logic                          first_byte_s1;
	logic                          last_byte_s1;

	logic [crc16_pkg::CrcW-1:0]    seed_value_q;
	logic                          bit_order_q;
	logic [crc16_pkg::CrcW-1:0]    running_rem_q;

	logic                          out_valid_q;
	logic [crc16_pkg::CrcW-1:0]    remainder_q;
	logic                          message_done_q;

	logic                          adv_out;
	logic                          adv_s1;
	logic [crc16_pkg::CrcW-1:0]    start_rem;
	logic [crc16_pkg::CrcW-1:0]    next_rem;

	// Handshake: result register drains or is empty, input register moves behind it
	assign adv_out   = !out_valid_q || !out_stall;
	assign adv_s1    = s1_valid_s1 && adv_out;
	assign in_stall  = s1_valid_s1 && !adv_out;
	assign cfg_ready = 1'b1;

	// Write configuration registers; ignore indexes beyond the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_value_q <= crc16_pkg::SeedReset;
			bit_order_q  <= crc16_pkg::OrderMsbFirst;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				crc16_pkg::CfgSeedValue: seed_value_q <= cfg_data;
				crc16_pkg::CfgBitOrder:  bit_order_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Capture the input item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			s1_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			data_byte_s1  <= data_byte;
			first_byte_s1 <= first_byte;
			last_byte_s1  <= last_byte;
		end
	end

	// Fold the held byte into the seed or the running remainder
	always_comb begin
		start_rem = first_byte_s1 ? seed_value_q : running_rem_q;
		if (bit_order_q == crc16_pkg::OrderLsbFirst) begin
			next_rem = crc16_pkg::fold_lsb_first(start_rem, data_byte_s1);
		end else begin
			next_rem = crc16_pkg::fold_msb_first(start_rem, data_byte_s1);
		end
	end

	// Advance the running remainder
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_rem_q <= crc16_pkg::SeedReset;
		end else if (adv_s1) begin
			running_rem_q <= next_rem;
		end
	end

	// Load the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_out) begin
			out_valid_q <= s1_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			remainder_q    <= next_rem;
			message_done_q <= last_byte_s1;
		end
	end

	assign out_valid    = out_valid_q;
	assign remainder    = remainder_q;
	assign message_done = message_done_q;

	// A stall on the input side only comes from a held item in the input register
	a_stall_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> s1_valid_s1)
		else $error("input stalled with empty input register");

	// A moved item shows up as the result, equal to the new running remainder
	a_result_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> (out_valid && remainder == running_rem_q))
		else $error("result does not match running remainder");

	// The running remainder only changes when an item moves on
	a_rem_holds_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s1 |=> $stable(running_rem_q))
		else $error("running remainder changed without an item");

	// A stalled item stays in the input register
	a_s1_holds_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> (s1_valid_s1 && $stable(data_byte_s1) && $stable(first_byte_s1)))
		else $error("input register changed under stall");

endmodule

>>> dv/crc16_ccitt_dual_order_unit_check.sv
// Channel monitor, CRC remainder predictor and result comparison for the dual-order CRC-16 unit.
module crc16_ccitt_dual_order_unit_check (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_stall,
	input  logic [crc16_pkg::ByteW-1:0]       data_byte,
	input  logic                              first_byte,
	input  logic                              last_byte,
	input  logic                              out_valid,
	input  logic                              out_stall,
	input  logic [crc16_pkg::CrcW-1:0]        remainder,
	input  logic                              message_done,
	input  logic                              cfg_valid,
	input  logic                              cfg_ready,
	input  logic [crc16_pkg::CfgIdxW-1:0]     cfg_index,
	input  logic [crc16_pkg::CrcW-1:0]        cfg_data,
	output int                                fail_count,
	output int                                pending_results
);

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [crc16_pkg::CrcW-1:0] crc;
		logic                       done;
	} crc_result_t;

	// Predictor copies of the registers and the running remainder
	logic [crc16_pkg::CrcW-1:0] seed_reg;
	logic                       order_reg;
	logic [crc16_pkg::CrcW-1:0] crc_run;
	crc_result_t                expected_crcs[$];

	// Fold one byte bit-serially in the selected order
	function automatic logic [crc16_pkg::CrcW-1:0] fold_byte(
		input logic [crc16_pkg::CrcW-1:0]  crc,
		input logic [crc16_pkg::ByteW-1:0] d,
		input logic                        order
	);
		logic [crc16_pkg::CrcW-1:0] r;
		logic                       fb;
		r = crc;
		for (int k = 0; k < crc16_pkg::ByteW; k++) begin
			if (order == crc16_pkg::OrderLsbFirst) begin
				fb = r[0] ^ d[k];
				r  = r >> 1;
				if (fb) r = r ^ crc16_pkg::PolyLsbFirst;
			end else begin
				fb = r[crc16_pkg::CrcW-1] ^ d[crc16_pkg::ByteW-1-k];
				r  = r << 1;
				if (fb) r = r ^ crc16_pkg::PolyMsbFirst;
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		crc_result_t got;
		crc_result_t exp_item;
		if (!arst_n) begin
			seed_reg   = crc16_pkg::SeedReset;
			order_reg  = crc16_pkg::OrderMsbFirst;
			crc_run    = crc16_pkg::SeedReset;
			fail_count = 0;
			expected_crcs.delete();
			pending_results = 0;
		end else begin
			// Compare an accepted result with the oldest prediction
			if (out_valid && !out_stall) begin
				got.crc  = remainder;
				got.done = message_done;
				if (expected_crcs.size() == 0) begin
					$error("remainder: no item expected, actual %h", got.crc);
					fail_count++;
				end else begin
					exp_item = expected_crcs.pop_front();
					if (got.crc !== exp_item.crc) begin
						$error("remainder: expected %h, actual %h", exp_item.crc, got.crc);
						fail_count++;
					end
					if (got.done !== exp_item.done) begin
						$error("message_done: expected %b, actual %b", exp_item.done,
							got.done);
						fail_count++;
					end
				end
			end
			// Predict the result of an accepted input item
			if (in_valid && !in_stall) begin
				crc_run = fold_byte(first_byte ? seed_reg : crc_run, data_byte, order_reg);
				exp_item.crc  = crc_run;
				exp_item.done = last_byte;
				expected_crcs.push_back(exp_item);
			end
			// Track register writes; unknown indexes are dropped
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					crc16_pkg::CfgSeedValue: seed_reg = cfg_data;
					crc16_pkg::CfgBitOrder:  order_reg = cfg_data[0];
					default: ;
				endcase
			end
			pending_results = expected_crcs.size();
		end
	end

endmodule

>>> dv/crc16_ccitt_dual_order_unit_test.sv
// Stimulus, idling control and verdict for the dual-order CRC-16 unit.
module crc16_ccitt_dual_order_unit_test;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CycleLimit = 300000;
	localparam int unsigned DrainCycles = 6;
	localparam int unsigned RandomItems = 1250;

	// Register indexes past the end of the list
	localparam logic [crc16_pkg::CfgIdxW-1:0] CfgSpareLo = 2'd2;
	localparam logic [crc16_pkg::CfgIdxW-1:0] CfgSpareHi = 2'd3;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	logic [crc16_pkg::ByteW-1:0]   data_byte = '0;
	logic                          first_byte = 1'b0;
	logic                          last_byte = 1'b0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic [crc16_pkg::CrcW-1:0]    remainder;
	logic                          message_done;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [crc16_pkg::CfgIdxW-1:0] cfg_index = '0;
	logic [crc16_pkg::CrcW-1:0]    cfg_data = '0;

	int fail_count;
	int pending_results;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int sent_count = 0;
	int unsigned cycle_count = 0;

	always #5 clk = ~clk;

	crc16_ccitt_dual_order_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.first_byte   (first_byte),
		.last_byte    (last_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.remainder    (remainder),
		.message_done (message_done),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	crc16_ccitt_dual_order_unit_check u_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.data_byte       (data_byte),
		.first_byte      (first_byte),
		.last_byte       (last_byte),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.remainder       (remainder),
		.message_done    (message_done),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.fail_count      (fail_count),
		.pending_results (pending_results)
	);

	// Stall the result channel at random
	always @(negedge clk) begin
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("** crc16_ccitt_dual_order_unit: FAILED **");
			$finish;
		end
	end

	// Offer one item, idling first at random; entered and left at a falling edge
	task automatic send_byte(input logic [crc16_pkg::ByteW-1:0] d, input logic f,
			input logic l);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid   <= 1'b1;
		data_byte  <= d;
		first_byte <= f;
		last_byte  <= l;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sent_count++;
		@(negedge clk);
	endtask

	// Hold the sender until every result is back and the pipeline is empty
	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending_results != 0) @(negedge clk);
		repeat (DrainCycles) @(negedge clk);
	endtask

	// Write one register; call only with the unit drained
	task automatic cfg_write(input logic [crc16_pkg::CfgIdxW-1:0] idx,
			input logic [crc16_pkg::CrcW-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Send a well-formed message of random bytes
	task automatic send_message(input int len);
		for (int i = 0; i < len; i++) begin
			send_byte(crc16_pkg::ByteW'($urandom), i == 0, i == len - 1);
		end
	endtask

	initial begin
		int phase;
		int phase_end;
		logic [crc16_pkg::CrcW-1:0] seed;

		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: byte with no first flag folds into the reset remainder
		send_byte(8'h00, 1'b0, 1'b0);
		send_byte(8'hFF, 1'b1, 1'b1);
		// Check string in MSB-first order, reset seed
		send_byte(8'h31, 1'b1, 1'b0);
		for (int c = 8'h32; c < 8'h39; c++) send_byte(crc16_pkg::ByteW'(c), 1'b0, 1'b0);
		send_byte(8'h39, 1'b0, 1'b1);
		// Keep folding after a last byte
		send_byte(8'hA5, 1'b0, 1'b0);

		// LSB-first with a zero seed
		drain();
		cfg_write(crc16_pkg::CfgSeedValue, 16'h0000);
		cfg_write(crc16_pkg::CfgBitOrder, crc16_pkg::CrcW'(crc16_pkg::OrderLsbFirst));
		send_byte(8'h00, 1'b1, 1'b0);
		send_byte(8'h80, 1'b0, 1'b0);
		send_byte(8'h01, 1'b0, 1'b1);

		// Switch bit order in the middle of a message
		send_byte(8'h5A, 1'b1, 1'b0);
		drain();
		cfg_write(crc16_pkg::CfgBitOrder, crc16_pkg::CrcW'(crc16_pkg::OrderMsbFirst));
		send_byte(8'hC3, 1'b0, 1'b1);

		// Change the seed mid-message; it applies at the next first byte
		send_byte(8'h12, 1'b1, 1'b0);
		drain();
		cfg_write(crc16_pkg::CfgSeedValue, 16'h1D0F);
		send_byte(8'h34, 1'b0, 1'b1);
		send_byte(8'h56, 1'b1, 1'b1);

		// Writes to unused indexes must not disturb anything
		drain();
		cfg_write(CfgSpareLo, 16'hFFFF);
		cfg_write(CfgSpareHi, 16'h0000);
		send_byte(8'h7E, 1'b1, 1'b1);
		send_byte(8'h81, 1'b0, 1'b1);

		// Random phases over the idling modes and register settings
		for (phase = 0; phase < 8; phase++) begin
			drain();
			case (phase % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 62; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 62; end
				default: begin send_idle_pct = 30; stall_pct = 30; end
			endcase
			case (phase)
				0: seed = 16'hFFFF;
				1: seed = 16'h0000;
				2: seed = 16'h8000;
				3: seed = 16'h0001;
				default: seed = crc16_pkg::CrcW'($urandom);
			endcase
			cfg_write(crc16_pkg::CfgSeedValue, seed);
			cfg_write(crc16_pkg::CfgBitOrder, crc16_pkg::CrcW'(phase[0]));
			if (phase == 5) cfg_write(CfgSpareHi, crc16_pkg::CrcW'($urandom));
			phase_end = sent_count + RandomItems / 8;
			while (sent_count < phase_end) begin
				if ($urandom_range(0, 9) == 0) begin
					send_byte(crc16_pkg::ByteW'($urandom), 1'($urandom), 1'($urandom));
				end else if ($urandom_range(0, 9) == 0) begin
					send_message($urandom_range(1, 40));
				end else begin
					send_message($urandom_range(1, 12));
				end
				// In phase 3, pause the sender after each message that ends in the 12 items past mid-phase
				if (phase == 3 && sent_count >= phase_end - RandomItems / 16 &&
						sent_count < phase_end - RandomItems / 16 + 12) begin
					drain();
				end
			end
		end

		drain();
		stall_pct = 0;
		repeat (DrainCycles) @(negedge clk);
		if (fail_count == 0 && pending_results == 0) begin
			$display("** crc16_ccitt_dual_order_unit: PASSED **");
		end else begin
			$display("** crc16_ccitt_dual_order_unit: FAILED **");
		end
		$finish;
	end

endmodule
